[rtl/smc_pkg.sv]
package smc_pkg;

  localparam logic [1:0] REQ_LOAD_MOVER  = 2'd0;
  localparam logic [1:0] REQ_LOAD_TARGET = 2'd1;
  localparam logic [1:0] REQ_CHECK       = 2'd2;

  localparam int POS_W   = 24;
  localparam int TIME_W  = 16;
  localparam int ROW_W   = 16;
  localparam int IDX_W   = 4;
  localparam int CELL_W  = 16;
  localparam int DIFF_W  = CELL_W + 1;
  localparam int SHAMT_W = 7;

  typedef struct packed {
    logic cap;
    logic wr_mover;
    logic wr_target;
    logic mul;
    logic sum;
    logic to_cell;
    logic diff;
    logic scan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

[rtl/smc_if.sv]
interface smc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            req_type;
  logic [smc_pkg::IDX_W-1:0]             row_index;
  logic [smc_pkg::ROW_W-1:0]             row_mask;
  logic signed [smc_pkg::POS_W-1:0]      mover_pos_x;
  logic signed [smc_pkg::POS_W-1:0]      mover_pos_y;
  logic signed [smc_pkg::POS_W-1:0]      mover_speed_x;
  logic signed [smc_pkg::POS_W-1:0]      mover_speed_y;
  logic [smc_pkg::TIME_W-1:0]            time_step;
  logic signed [smc_pkg::POS_W-1:0]      target_pos_x;
  logic signed [smc_pkg::POS_W-1:0]      target_pos_y;
  logic                                  same_object;

  modport source (
    output valid, req_type, row_index, row_mask, mover_pos_x, mover_pos_y,
           mover_speed_x, mover_speed_y, time_step, target_pos_x, target_pos_y,
           same_object,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, row_mask, mover_pos_x, mover_pos_y,
           mover_speed_x, mover_speed_y, time_step, target_pos_x, target_pos_y,
           same_object,
    output ready
  );
endinterface

interface smc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               collide;
  logic signed [smc_pkg::CELL_W-1:0]  next_cell_x;
  logic signed [smc_pkg::CELL_W-1:0]  next_cell_y;

  modport source (output valid, collide, next_cell_x, next_cell_y, input ready);
  modport sink (input valid, collide, next_cell_x, next_cell_y, output ready);
endinterface

[rtl/smc_ram.sv]
module smc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/smc_datapath.sv]
module smc_datapath #(
  parameter int MASK_WIDTH  = 16,
  parameter int MASK_HEIGHT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  smc_pkg::dp_cmd_t                      cmd,
  output smc_pkg::dp_sts_t                      sts,
  input  logic [smc_pkg::IDX_W-1:0]             row_index,
  input  logic [smc_pkg::ROW_W-1:0]             row_mask,
  input  logic signed [smc_pkg::POS_W-1:0]      mover_pos_x,
  input  logic signed [smc_pkg::POS_W-1:0]      mover_pos_y,
  input  logic signed [smc_pkg::POS_W-1:0]      mover_speed_x,
  input  logic signed [smc_pkg::POS_W-1:0]      mover_speed_y,
  input  logic [smc_pkg::TIME_W-1:0]            time_step,
  input  logic signed [smc_pkg::POS_W-1:0]      target_pos_x,
  input  logic signed [smc_pkg::POS_W-1:0]      target_pos_y,
  input  logic                                  same_object,
  output logic                                  collide,
  output logic signed [smc_pkg::CELL_W-1:0]     next_cell_x,
  output logic signed [smc_pkg::CELL_W-1:0]     next_cell_y
);

  localparam int AW     = (MASK_HEIGHT > 1) ? $clog2(MASK_HEIGHT) : 1;
  localparam int CW     = $clog2(MASK_HEIGHT + 1);
  localparam int REXT_W = ((AW > smc_pkg::IDX_W) ? AW : smc_pkg::IDX_W) + 1;
  localparam int XW     = (MASK_WIDTH > smc_pkg::ROW_W) ? MASK_WIDTH : smc_pkg::ROW_W;
  localparam int PW     = smc_pkg::POS_W + smc_pkg::TIME_W + 1;
  localparam int SW     = PW + 1;
  localparam int QW     = SW - 16;
  localparam int IW     = 18;
  localparam int SHAMT_W_L = smc_pkg::SHAMT_W;

  function automatic logic signed [smc_pkg::CELL_W-1:0] cell_of(input logic signed [SW-1:0] s);
    logic              rnd;
    logic signed [QW-1:0] q;
    rnd = s[SW-1] & (|s[15:0]);
    q   = $signed(s[SW-1:16]) + $signed({{(QW-1){1'b0}}, rnd});
    if (q > $signed(QW'(32767))) begin
      cell_of = 16'sh7fff;
    end else if (q < $signed(-QW'(32768))) begin
      cell_of = -16'sh8000;
    end else begin
      cell_of = q[smc_pkg::CELL_W-1:0];
    end
  endfunction

  function automatic logic signed [smc_pkg::CELL_W-1:0] tcell_of(
    input logic signed [smc_pkg::POS_W-1:0] p);
    logic rnd;
    rnd = p[smc_pkg::POS_W-1] & (|p[7:0]);
    tcell_of = $signed(p[smc_pkg::POS_W-1:8]) + $signed({15'd0, rnd});
  endfunction

  // captured check operands
  logic signed [smc_pkg::POS_W-1:0]  px_r, py_r, vx_r, vy_r, tpx_r, tpy_r;
  logic [smc_pkg::TIME_W-1:0]        t_r;
  logic                              same_r;

  logic signed [PW-1:0]              prod_x_r, prod_y_r;
  logic signed [SW-1:0]              sum_x_r, sum_y_r;
  logic signed [smc_pkg::CELL_W-1:0] nx_r, ny_r, tx_r, ty_r;
  logic signed [smc_pkg::DIFF_W-1:0] dx_w, dy_w, dy_r, dx_mag;
  logic                              near_r, shl_r;
  logic [SHAMT_W_L-1:0]              shamt_r;

  logic [CW-1:0]                     cnt_r;
  logic                              rd_ok_r, hit_r;
  logic [MASK_HEIGHT-1:0]            mvld_r, tvld_r;
  logic signed [IW-1:0]              i_s;
  logic                              row_live, tgt_in;

  logic [REXT_W-1:0]                 wrow;
  logic                              wr_ok;
  logic [XW-1:0]                     wext;
  logic [MASK_WIDTH-1:0]             mrd, trd, tsh;

  logic                              coll_out_r;
  logic signed [smc_pkg::CELL_W-1:0] nx_out_r, ny_out_r;

  assign wrow  = REXT_W'(row_index);
  assign wr_ok = wrow < REXT_W'(MASK_HEIGHT);
  assign wext  = XW'(row_mask);

  assign i_s      = $signed(IW'(cnt_r)) - IW'(dy_r);
  assign row_live = cnt_r < CW'(MASK_HEIGHT);
  assign tgt_in   = (i_s >= 0) && (i_s < $signed(IW'(MASK_HEIGHT)));

  smc_ram #(.WIDTH(MASK_WIDTH), .DEPTH(MASK_HEIGHT)) u_mover_ram (
    .clk   (clk),
    .we    (cmd.wr_mover & wr_ok),
    .waddr (wrow[AW-1:0]),
    .wdata (wext[MASK_WIDTH-1:0]),
    .raddr (cnt_r[AW-1:0]),
    .rdata (mrd)
  );

  smc_ram #(.WIDTH(MASK_WIDTH), .DEPTH(MASK_HEIGHT)) u_target_ram (
    .clk   (clk),
    .we    (cmd.wr_target & wr_ok),
    .waddr (wrow[AW-1:0]),
    .wdata (wext[MASK_WIDTH-1:0]),
    .raddr (i_s[AW-1:0]),
    .rdata (trd)
  );

  assign dx_w   = smc_pkg::DIFF_W'(tx_r) - smc_pkg::DIFF_W'(nx_r);
  assign dy_w   = smc_pkg::DIFF_W'(ty_r) - smc_pkg::DIFF_W'(ny_r);
  assign dx_mag = dx_w[smc_pkg::DIFF_W-1] ? -dx_w : dx_w;
  assign tsh    = shl_r ? (trd << shamt_r) : (trd >> shamt_r);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      px_r   <= mover_pos_x;
      py_r   <= mover_pos_y;
      vx_r   <= mover_speed_x;
      vy_r   <= mover_speed_y;
      t_r    <= time_step;
      tpx_r  <= target_pos_x;
      tpy_r  <= target_pos_y;
      same_r <= same_object;
    end
    if (cmd.mul) begin
      prod_x_r <= vx_r * $signed({1'b0, t_r});
      prod_y_r <= vy_r * $signed({1'b0, t_r});
    end
    if (cmd.sum) begin
      sum_x_r <= SW'(prod_x_r) + SW'($signed({px_r, 8'd0}));
      sum_y_r <= SW'(prod_y_r) + SW'($signed({py_r, 8'd0}));
    end
    if (cmd.to_cell) begin
      nx_r <= cell_of(sum_x_r);
      ny_r <= cell_of(sum_y_r);
      tx_r <= tcell_of(tpx_r);
      ty_r <= tcell_of(tpy_r);
    end
    if (cmd.diff) begin
      dy_r    <= dy_w;
      near_r  <= !same_r
                 && (dx_w < smc_pkg::DIFF_W'(MASK_WIDTH))
                 && (dx_w > -smc_pkg::DIFF_W'(MASK_WIDTH))
                 && (dy_w < smc_pkg::DIFF_W'(MASK_HEIGHT))
                 && (dy_w > -smc_pkg::DIFF_W'(MASK_HEIGHT));
      shl_r   <= !dx_w[smc_pkg::DIFF_W-1];
      shamt_r <= dx_mag[SHAMT_W_L-1:0];
    end
    if (cmd.out_load) begin
      coll_out_r <= hit_r;
      nx_out_r   <= nx_r;
      ny_out_r   <= ny_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r  <= '0;
      tvld_r  <= '0;
      cnt_r   <= '0;
      rd_ok_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.wr_mover && wr_ok) begin
        mvld_r[wrow[AW-1:0]] <= 1'b1;
      end
      if (cmd.wr_target && wr_ok) begin
        tvld_r[wrow[AW-1:0]] <= 1'b1;
      end
      if (cmd.diff) begin
        cnt_r   <= '0;
        rd_ok_r <= 1'b0;
        hit_r   <= 1'b0;
      end else if (cmd.scan) begin
        if (row_live) begin
          cnt_r <= cnt_r + 1'b1;
        end
        rd_ok_r <= row_live && near_r && tgt_in
                   && mvld_r[cnt_r[AW-1:0]] && tvld_r[i_s[AW-1:0]];
        hit_r   <= hit_r | (rd_ok_r & (|(mrd & tsh)));
      end
    end
  end

  assign sts.scan_last = (cnt_r == CW'(MASK_HEIGHT));
  assign collide       = coll_out_r;
  assign next_cell_x   = nx_out_r;
  assign next_cell_y   = ny_out_r;

endmodule

[rtl/smc_ctrl.sv]
module smc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         req_type,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output smc_pkg::dp_cmd_t   cmd,
  input  smc_pkg::dp_sts_t   sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_CELL = 3'd3;
  localparam logic [2:0] S_DIFF = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            smc_pkg::REQ_LOAD_MOVER:  cmd.wr_mover  = 1'b1;
            smc_pkg::REQ_LOAD_TARGET: cmd.wr_target = 1'b1;
            smc_pkg::REQ_CHECK: begin
              cmd.cap   = 1'b1;
              state_nxt = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CELL;
      end
      S_CELL: begin
        cmd.to_cell = 1'b1;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_vld_nxt = (out_vld_r & ~out_ready) | cmd.out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

endmodule

[rtl/sprite_mask_collision.sv]
// Sprite mask collision checker. Load items write one row of the mover or
// target occupancy mask and give no result. A check item forms the next cell
// position and the cell offset in the multiply, sum, cell conversion and
// difference steps, then runs a row scan through the two mask memories (one
// row read per cycle, registered read), then loads the result register once
// any earlier result has been accepted. The result register holds a finished
// result while the next item is taken in.
module sprite_mask_collision #(
  parameter int MASK_WIDTH  = 16,
  parameter int MASK_HEIGHT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  smc_in_if.sink     in_ch,
  smc_out_if.source  out_ch
);

  smc_pkg::dp_cmd_t cmd;
  smc_pkg::dp_sts_t sts;

  smc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .req_type  (in_ch.req_type),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  smc_datapath #(
    .MASK_WIDTH  (MASK_WIDTH),
    .MASK_HEIGHT (MASK_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .row_index     (in_ch.row_index),
    .row_mask      (in_ch.row_mask),
    .mover_pos_x   (in_ch.mover_pos_x),
    .mover_pos_y   (in_ch.mover_pos_y),
    .mover_speed_x (in_ch.mover_speed_x),
    .mover_speed_y (in_ch.mover_speed_y),
    .time_step     (in_ch.time_step),
    .target_pos_x  (in_ch.target_pos_x),
    .target_pos_y  (in_ch.target_pos_y),
    .same_object   (in_ch.same_object),
    .collide       (out_ch.collide),
    .next_cell_x   (out_ch.next_cell_x),
    .next_cell_y   (out_ch.next_cell_y)
  );

endmodule
